// ===== src/fqd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg: shared constants for the queue with delete
// Sizes of the entry store and codes of the commands.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

endpackage

// ===== src/fqd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fifo_queue_with_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete: bounded queue of handles with delete by value
// An enqueue or any rejected command goes from the idle state to the finish
// state; a dequeue or delete first passes the scan state, which reads one entry
// per cycle over the live entries from the single read port of the entry RAM.
// One command at a time: a new one is taken only in the idle state.
// Reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fqd_pkg::CMD_W-1:0]  cmd,
  input  logic [fqd_pkg::DATA_W-1:0] item_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       status,
  output logic [fqd_pkg::DATA_W-1:0] head_value,
  output logic [fqd_pkg::CNT_W-1:0]  entry_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                   state;
  logic [fqd_pkg::CNT_W-1:0]    count;
  logic [fqd_pkg::CMD_W-1:0]    cmd_q;
  logic [fqd_pkg::DATA_W-1:0]   val_q;
  logic [fqd_pkg::DATA_W-1:0]   head_q;
  logic                         err_q;
  logic                         found;
  logic [fqd_pkg::ADDR_W-1:0]   jidx;

  logic                         we;
  logic [fqd_pkg::ADDR_W-1:0]   waddr;
  logic [fqd_pkg::DATA_W-1:0]   wdata;
  logic [fqd_pkg::ADDR_W-1:0]   raddr;
  logic [fqd_pkg::DATA_W-1:0]   rdata;

  logic                         match;
  logic                         last;
  logic                         enq_ok;
  logic                         scan_ok;

  fqd_ram #(
    .WIDTH(fqd_pkg::DATA_W),
    .DEPTH(fqd_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign match    = !found && ((cmd_q == fqd_pkg::CMD_DEQ) || (rdata == val_q));
  assign last     = (fqd_pkg::CNT_W'(jidx) == count - 1'b1);
  assign enq_ok   = (cmd == fqd_pkg::CMD_ENQ) && (item_value != '0) &&
                    (count < fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
  assign scan_ok  = (count != '0) &&
                    ((cmd == fqd_pkg::CMD_DEQ) ||
                     ((cmd == fqd_pkg::CMD_DEL) && (item_value != '0)));

  always_comb begin
    we    = 1'b0;
    waddr = jidx - 1'b1;
    wdata = rdata;
    raddr = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && enq_ok) begin
          we    = 1'b1;
          waddr = count[fqd_pkg::ADDR_W-1:0];
          wdata = item_value;
        end
      end
      ST_RUN: begin
        we    = found;
        raddr = jidx + 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state != ST_FIN) && out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q  <= cmd;
            val_q  <= item_value;
            head_q <= '0;
            found  <= 1'b0;
            jidx   <= '0;
            if (enq_ok) begin
              count <= count + 1'b1;
              err_q <= 1'b0;
              state <= ST_FIN;
            end else if (scan_ok) begin
              state <= ST_RUN;
            end else begin
              err_q <= 1'b1;
              state <= ST_FIN;
            end
          end
        end
        ST_RUN: begin
          if (match) begin
            found <= 1'b1;
            if (cmd_q == fqd_pkg::CMD_DEQ) begin
              head_q <= rdata;
            end
          end
          if (last) begin
            err_q <= !(found || match);
            if (found || match) begin
              count <= count - 1'b1;
            end
            state <= ST_FIN;
          end else begin
            jidx <= jidx + 1'b1;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= err_q;
            head_value  <= err_q ? '0 : head_q;
            entry_count <= count;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_fifo_queue_with_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_delete: self-checking bench for the queue with delete
// A shadow queue predicts status, dequeued handle and entry count for every
// accepted command, and each result is compared in order against it.
// Directed commands cover empty, full, null and not-found cases and
// duplicate handles. Random phases then bias the command mix toward
// filling, draining or deleting live handles, with bursty input traffic and
// random and patterned output stalls.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_delete;

  localparam logic [fqd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int                        RAND_PHASES = 9;
  localparam int                        PHASE_ITEMS = 125;

  typedef struct {
    logic                       status;
    logic [fqd_pkg::DATA_W-1:0] head;
    logic [fqd_pkg::CNT_W-1:0]  count;
  } queue_response_t;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_DELETE, MIX_NOISE} cmd_mix_t;
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_COMB} rx_mode_t;

  class handle_queue_checker;
    logic [fqd_pkg::DATA_W-1:0] entries[$];
    queue_response_t            pending_responses[$];
    int                         mismatches = 0;

    function void note_command(logic [fqd_pkg::CMD_W-1:0] c,
                               logic [fqd_pkg::DATA_W-1:0] v);
      queue_response_t r;
      int              hit;
      r.status = 1'b1;
      r.head   = '0;
      case (c)
        fqd_pkg::CMD_ENQ: begin
          if (v != '0 && entries.size() < fqd_pkg::DEPTH) begin
            entries.push_back(v);
            r.status = 1'b0;
          end
        end
        fqd_pkg::CMD_DEQ: begin
          if (entries.size() > 0) begin
            r.head   = entries.pop_front();
            r.status = 1'b0;
          end
        end
        fqd_pkg::CMD_DEL: begin
          hit = -1;
          if (v != '0) begin
            for (int i = 0; i < entries.size(); i++) begin
              if (hit < 0 && entries[i] == v) hit = i;
            end
          end
          if (hit >= 0) begin
            entries.delete(hit);
            r.status = 1'b0;
          end
        end
        default: ;
      endcase
      r.count = fqd_pkg::CNT_W'(entries.size());
      pending_responses.push_back(r);
    endfunction

    function void check_result(logic st, logic [fqd_pkg::DATA_W-1:0] hd,
                               logic [fqd_pkg::CNT_W-1:0] cnt);
      queue_response_t r;
      if (pending_responses.size() == 0) begin
        $display("%0t: result with none expected: status %0d head %h count %0d",
                 $time, st, hd, cnt);
        mismatches++;
        return;
      end
      r = pending_responses.pop_front();
      if (st !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
        mismatches++;
      end
      if (hd !== r.head) begin
        $display("%0t: head_value expected %h actual %h", $time, r.head, hd);
        mismatches++;
      end
      if (cnt !== r.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, r.count, cnt);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_responses.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [fqd_pkg::CMD_W-1:0]  cmd = fqd_pkg::CMD_ENQ;
  logic [fqd_pkg::DATA_W-1:0] item_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       status;
  logic [fqd_pkg::DATA_W-1:0] head_value;
  logic [fqd_pkg::CNT_W-1:0]  entry_count;

  rx_mode_t          rx_mode = RX_OPEN;
  int                rx_mode_left = 0;
  logic [1:0]        rx_tick = '0;

  handle_queue_checker sb = new();

  fifo_queue_with_delete u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .head_value  (head_value),
    .entry_count (entry_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 2'd1;
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
      RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
      default:   out_ready <= (rx_tick == 2'd0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, head_value, entry_count);
  end

  task automatic send_cmd(input logic [fqd_pkg::CMD_W-1:0] c,
                          input logic [fqd_pkg::DATA_W-1:0] v);
    in_valid   <= 1'b1;
    cmd        <= c;
    item_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(c, v);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  function automatic logic [fqd_pkg::DATA_W-1:0] pick_handle(bit prefer_live);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (prefer_live && sb.entries.size() > 0 && roll < 60)
      return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
    if (roll < 75) return fqd_pkg::DATA_W'($urandom_range(1, 12));
    return $urandom;
  endfunction

  task automatic send_random(input cmd_mix_t mix);
    int enq_w;
    int deq_w;
    int del_w;
    int roll;
    case (mix)
      MIX_FILL:   begin enq_w = 65; deq_w = 10; del_w = 20; end
      MIX_DRAIN:  begin enq_w = 20; deq_w = 50; del_w = 25; end
      MIX_DELETE: begin enq_w = 45; deq_w = 10; del_w = 42; end
      MIX_NOISE:  begin enq_w = 30; deq_w = 25; del_w = 25; end
      default:    begin enq_w = 40; deq_w = 30; del_w = 25; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < enq_w)
      send_cmd(fqd_pkg::CMD_ENQ, pick_handle(1'b0));
    else if (roll < enq_w + deq_w)
      send_cmd(fqd_pkg::CMD_DEQ, $urandom);
    else if (roll < enq_w + deq_w + del_w)
      send_cmd(fqd_pkg::CMD_DEL, pick_handle(1'b1));
    else
      send_cmd(CMD_UNUSED, $urandom);
  endtask

  initial begin
    int       burst_left;
    int       gap;
    cmd_mix_t mix;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(fqd_pkg::CMD_DEQ, 32'h0000_0000);
    send_cmd(fqd_pkg::CMD_DEL, 32'h0000_0005);
    send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0000);
    for (int i = 0; i < fqd_pkg::DEPTH; i++) begin
      if (i == 0)
        send_cmd(fqd_pkg::CMD_ENQ, 32'hFFFF_FFFF);
      else if (i == fqd_pkg::DEPTH - 1)
        send_cmd(fqd_pkg::CMD_ENQ, 32'h8000_0000);
      else if (i == 3 || i == 9)
        send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0007);
      else
        send_cmd(fqd_pkg::CMD_ENQ, 32'h1000_0000 | fqd_pkg::DATA_W'(i));
    end
    send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0001);
    send_cmd(fqd_pkg::CMD_DEL, 32'h0000_0000);
    send_cmd(fqd_pkg::CMD_DEL, 32'h1234_5678);
    send_cmd(fqd_pkg::CMD_DEL, 32'h0000_0007);
    send_cmd(fqd_pkg::CMD_DEL, 32'h8000_0000);
    send_cmd(fqd_pkg::CMD_DEL, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED, 32'h0000_0009);
    send_cmd(fqd_pkg::CMD_DEQ, 32'hFFFF_FFFF);
    wait_drained();

    burst_left = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      mix = cmd_mix_t'(p % 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_random(mix);
        burst_left--;
      end
      if (p == 2 || p == 5) wait_drained();
    end

    wait_drained();
    repeat (fqd_pkg::DEPTH + 4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fqd_pkg.sv
src/fqd_ram.sv
src/fifo_queue_with_delete.sv
sim/tb_fifo_queue_with_delete.sv
